FILE: rtl/core/weas_pkg.sv
// ----------------------------------------------------------------------------
// Event alert sequencer package
// Shared constants, word layouts and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package weas_pkg;

	localparam int TIME_BITS_DEF = 32;

	// Event modes, as reported in fsm_state.
	localparam logic [2:0] MODE_IDLE      = 3'd0;
	localparam logic [2:0] MODE_MONITOR   = 3'd1;
	localparam logic [2:0] MODE_CAND      = 3'd2;
	localparam logic [2:0] MODE_ALERT     = 3'd3;
	localparam logic [2:0] MODE_CONFIRMED = 3'd4;
	localparam logic [2:0] MODE_REJECTED  = 3'd5;
	localparam logic [2:0] MODE_COOLDOWN  = 3'd6;

	// Input opcodes.
	localparam logic [1:0] OP_UPDATE  = 2'd0;
	localparam logic [1:0] OP_CONFIRM = 2'd1;
	localparam logic [1:0] OP_REJECT  = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	// Labels.
	localparam logic [2:0] LABEL_NONE      = 3'd0;
	localparam logic [2:0] LABEL_USER_MAX  = 3'd4;
	localparam logic [2:0] LABEL_FALSE_POS = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] CFG_CONF_THRESHOLD = 3'd0;
	localparam logic [2:0] CFG_ACTIVITY_LIMIT = 3'd1;
	localparam logic [2:0] CFG_TRIGGER_MS     = 3'd2;
	localparam logic [2:0] CFG_COOLDOWN_MS    = 3'd3;
	localparam logic [2:0] CFG_ALERT_TIMEOUT  = 3'd4;

	// Configuration reset values.
	localparam logic [15:0] RST_CONF_THRESHOLD = 16'd45875;
	localparam logic [15:0] RST_ACTIVITY_LIMIT = 16'd512;
	localparam logic [31:0] RST_TRIGGER_MS     = 32'd30000;
	localparam logic [31:0] RST_COOLDOWN_MS    = 32'd300000;
	localparam logic [31:0] RST_ALERT_TIMEOUT  = 32'd60000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] now_ms;
		logic        signal_ok;
		logic        worn;
		logic [15:0] conf_level;
		logic [15:0] motion_level;
		logic [7:0]  reason_bits;
		logic [15:0] heart_rate;
		logic [15:0] hrv_rmssd;
		logic [2:0]  user_label;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  fsm_state;
		logic        refused;
		logic        record_valid;
		logic [15:0] rec_confidence;
		logic [7:0]  rec_reasons;
		logic [15:0] rec_heart_rate;
		logic [15:0] rec_rmssd;
		logic [15:0] rec_activity;
		logic [2:0]  rec_label;
		logic [15:0] rec_seq;
	} out_word_t;

	// Controller to datapath.
	typedef struct packed {
		logic       load_item;
		logic       commit;
		logic       mode_we;
		logic [2:0] mode_nxt;
		logic       cand_init;
		logic       cand_accum;
		logic       seq_inc;
		logic       label_we;
		logic [2:0] label_val;
		logic       finish_we;
		logic       refused;
		logic       out_load;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] opcode;
		logic [2:0] label;
		logic       ok;
		logic       conf_ge;
		logic       act_lt;
		logic       trig_hit;
		logic       cool_run;
		logic       alert_to;
		logic       div_done;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/wearable_event_alert_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Wearable event alert sequencer
// Qualifies physiological events from a stream of inference words through
// idle, monitoring, candidate, alerting, confirmed, rejected and cooldown,
// and returns the event mode and record for every word taken in.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload                 Direction
//  in        in_valid / in_ready    in_word  (in_word_t)    into the block
//  out       out_valid / out_ready  out_word (out_word_t)   out of the block
//  cfg       cfg_we                 cfg_index, cfg_data     into the block
//
// A word passes from its acceptance through the decision state to the hand-off state, where
// its result is loaded; an update that extends a candidate waits in the divider state between
// them, and the divider skips its iterations when the running average saturates.
// The next word is taken once the result is in the output register; a stall on out_ready
// holds that register and keeps the following result waiting in the hand-off state.
// Reset is asynchronous and active low, restores the defaults, idle mode and a zero record.
// ----------------------------------------------------------------------------
`default_nettype none

module wearable_event_alert_sequencer_unit #(
	// Width of the wrapping millisecond time base.
	parameter int TIME_BITS = weas_pkg::TIME_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire weas_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output weas_pkg::out_word_t      out_word,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	// The controller only sees the datapath status (mode, opcode, label and the decision flags);
	// the configuration, the event state and record, and the divider live in the datapath.
	weas_pkg::dp_cmd_t  cmd;
	weas_pkg::dp_stat_t stat;

	weas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Time values are held at TIME_BITS and compared against the 32-bit
	// intervals after widening both sides, so differences wrap at 2^TIME_BITS.
	weas_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.stat      (stat),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

FILE: rtl/core/weas_div.sv
// ----------------------------------------------------------------------------
// Average divider
// Restoring divider, one quotient bit a cycle, giving a 16-bit quotient that
// saturates at its maximum when the true quotient does not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module weas_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [15:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] dvd_q;
	logic [15:0] den_q;
	logic [15:0] quo_q;
	logic [16:0] shifted;
	logic        fits;

	assign shifted = {rem_q, dvd_q[15]};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// The quotient overflows 16 bits exactly when the top half of the
				// dividend is not below the divisor.
				if (dividend[31:16] >= divisor) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'hF) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[31:16];
			dvd_q <= dividend[15:0];
			den_q <= divisor;
			quo_q <= '1;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			if (fits) begin
				rem_q <= 16'(shifted - {1'b0, den_q});
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/weas_dp.sv
// ----------------------------------------------------------------------------
// Event alert sequencer datapath
// Configuration, timing and candidate state, the event record, the averaging
// divider and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module weas_dp #(
	parameter int TIME_BITS = weas_pkg::TIME_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire weas_pkg::in_word_t in_word,
	input  wire weas_pkg::dp_cmd_t  cmd,
	output weas_pkg::dp_stat_t      stat,
	output weas_pkg::out_word_t     out_word
);

	localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

	logic [15:0]          thr_q, act_lim_q;
	logic [31:0]          trig_q, cool_q, tmo_q;

	weas_pkg::in_word_t   item_q;
	logic [2:0]           mode_q;
	logic [TIME_BITS-1:0] enter_q, cand_q, finish_q;
	logic [31:0]          total_q;
	logic [15:0]          samples_q;
	logic [15:0]          counter_q;
	logic                 refused_q;

	logic [15:0]          r_conf_q, r_hr_q, r_rmssd_q, r_act_q, r_seq_q;
	logic [7:0]           r_reasons_q;
	logic [2:0]           r_label_q;

	logic [TIME_BITS-1:0] now_t, el_cand, el_enter, el_finish;
	logic [32:0]          sum_ext;
	logic [31:0]          total_nxt;
	logic [15:0]          samples_nxt;
	logic [15:0]          counter_nxt;
	logic                 div_done;
	logic [15:0]          div_quo;
	logic                 rec_valid;

	assign now_t     = TIME_BITS'(item_q.now_ms);
	assign el_cand   = now_t - cand_q;
	assign el_enter  = now_t - enter_q;
	assign el_finish = now_t - finish_q;

	assign sum_ext     = {1'b0, total_q} + {17'd0, item_q.conf_level};
	assign total_nxt   = sum_ext[32] ? '1 : sum_ext[31:0];
	assign samples_nxt = (samples_q == 16'hFFFF) ? samples_q : samples_q + 16'd1;
	assign counter_nxt = counter_q + 16'd1;

	always_comb begin
		stat.mode     = mode_q;
		stat.opcode   = item_q.opcode;
		stat.label    = item_q.user_label;
		stat.ok       = item_q.signal_ok & item_q.worn;
		stat.conf_ge  = (item_q.conf_level >= thr_q);
		stat.act_lt   = (item_q.motion_level < act_lim_q);
		stat.trig_hit = (CW'(el_cand) >= CW'(trig_q));
		stat.cool_run = (CW'(el_finish) < CW'(cool_q));
		stat.alert_to = (CW'(el_enter) > CW'(tmo_q));
		stat.div_done = div_done;
	end

	weas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.commit & cmd.cand_accum),
		.dividend (total_nxt),
		.divisor  (samples_nxt),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= weas_pkg::RST_CONF_THRESHOLD;
			act_lim_q <= weas_pkg::RST_ACTIVITY_LIMIT;
			trig_q    <= weas_pkg::RST_TRIGGER_MS;
			cool_q    <= weas_pkg::RST_COOLDOWN_MS;
			tmo_q     <= weas_pkg::RST_ALERT_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				weas_pkg::CFG_CONF_THRESHOLD: thr_q     <= cfg_data[15:0];
				weas_pkg::CFG_ACTIVITY_LIMIT: act_lim_q <= cfg_data[15:0];
				weas_pkg::CFG_TRIGGER_MS:     trig_q    <= cfg_data;
				weas_pkg::CFG_COOLDOWN_MS:    cool_q    <= cfg_data;
				weas_pkg::CFG_ALERT_TIMEOUT:  tmo_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (cmd.load_item) begin
			item_q <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= weas_pkg::MODE_IDLE;
			enter_q     <= '0;
			cand_q      <= '0;
			finish_q    <= '0;
			total_q     <= '0;
			samples_q   <= '0;
			counter_q   <= '0;
			refused_q   <= 1'b0;
			r_conf_q    <= '0;
			r_reasons_q <= '0;
			r_hr_q      <= '0;
			r_rmssd_q   <= '0;
			r_act_q     <= '0;
			r_label_q   <= weas_pkg::LABEL_NONE;
			r_seq_q     <= '0;
		end else begin
			if (cmd.commit) begin
				refused_q <= cmd.refused;
				if (cmd.mode_we) begin
					mode_q  <= cmd.mode_nxt;
					enter_q <= now_t;
				end
				if (cmd.finish_we) begin
					finish_q <= now_t;
				end
				if (cmd.label_we) begin
					r_label_q <= cmd.label_val;
				end
				if (cmd.cand_init) begin
					cand_q      <= now_t;
					total_q     <= {16'd0, item_q.conf_level};
					samples_q   <= 16'd1;
					r_conf_q    <= item_q.conf_level;
					r_reasons_q <= item_q.reason_bits;
					r_hr_q      <= item_q.heart_rate;
					r_rmssd_q   <= item_q.hrv_rmssd;
					r_act_q     <= item_q.motion_level;
					r_label_q   <= weas_pkg::LABEL_NONE;
					r_seq_q     <= '0;
				end
				if (cmd.cand_accum) begin
					total_q   <= total_nxt;
					samples_q <= samples_nxt;
					r_hr_q    <= item_q.heart_rate;
					r_rmssd_q <= item_q.hrv_rmssd;
				end
				if (cmd.seq_inc) begin
					counter_q <= counter_nxt;
					r_seq_q   <= counter_nxt;
				end
			end
			if (div_done) begin
				r_conf_q <= div_quo;
			end
		end
	end

	assign rec_valid = (mode_q == weas_pkg::MODE_ALERT) ||
	                   (mode_q == weas_pkg::MODE_CONFIRMED);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_word.fsm_state      <= mode_q;
			out_word.refused        <= refused_q;
			out_word.record_valid   <= rec_valid;
			out_word.rec_confidence <= rec_valid ? r_conf_q : '0;
			out_word.rec_reasons    <= rec_valid ? r_reasons_q : '0;
			out_word.rec_heart_rate <= rec_valid ? r_hr_q : '0;
			out_word.rec_rmssd      <= rec_valid ? r_rmssd_q : '0;
			out_word.rec_activity   <= rec_valid ? r_act_q : '0;
			out_word.rec_label      <= rec_valid ? r_label_q : weas_pkg::LABEL_NONE;
			out_word.rec_seq        <= rec_valid ? r_seq_q : '0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/weas_ctrl.sv
// ----------------------------------------------------------------------------
// Event alert sequencer controller
// Sequences each word through decision, averaging and result hand-off, and
// decides the event transitions from the datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module weas_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire weas_pkg::dp_stat_t stat,
	output weas_pkg::dp_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CALC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       label_ok;
	logic       out_free;

	assign label_ok = (stat.label != weas_pkg::LABEL_NONE) &&
	                  (stat.label <= weas_pkg::LABEL_USER_MAX);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Event decision, applied by the datapath when commit is high.
	always_comb begin
		cmd            = '0;
		cmd.load_item  = in_valid && (state_q == S_IDLE);
		cmd.commit     = (state_q == S_CALC);
		cmd.out_load   = (state_q == S_OUT) && out_free;
		cmd.mode_nxt   = stat.mode;
		cmd.label_val  = stat.label;

		unique case (stat.opcode)
			weas_pkg::OP_UPDATE: begin
				unique case (stat.mode)
					weas_pkg::MODE_MONITOR: begin
						if (!stat.ok) begin
							cmd.mode_we  = 1'b1;
							cmd.mode_nxt = weas_pkg::MODE_IDLE;
						end else if (stat.conf_ge && stat.act_lt) begin
							cmd.cand_init = 1'b1;
							cmd.mode_we   = 1'b1;
							cmd.mode_nxt  = weas_pkg::MODE_CAND;
						end
					end
					weas_pkg::MODE_CAND: begin
						if (!stat.ok || !stat.act_lt || !stat.conf_ge) begin
							cmd.mode_we  = 1'b1;
							cmd.mode_nxt = weas_pkg::MODE_MONITOR;
						end else begin
							cmd.cand_accum = 1'b1;
							if (stat.trig_hit) begin
								cmd.mode_we = 1'b1;
								if (stat.cool_run) begin
									cmd.mode_nxt = weas_pkg::MODE_COOLDOWN;
								end else begin
									cmd.seq_inc  = 1'b1;
									cmd.mode_nxt = weas_pkg::MODE_ALERT;
								end
							end
						end
					end
					weas_pkg::MODE_ALERT: begin
						if (stat.alert_to) begin
							cmd.mode_we  = 1'b1;
							cmd.mode_nxt = weas_pkg::MODE_REJECTED;
						end
					end
					weas_pkg::MODE_CONFIRMED, weas_pkg::MODE_REJECTED: begin
						cmd.finish_we = 1'b1;
						cmd.mode_we   = 1'b1;
						cmd.mode_nxt  = weas_pkg::MODE_COOLDOWN;
					end
					weas_pkg::MODE_COOLDOWN: begin
						if (!stat.cool_run) begin
							cmd.mode_we  = 1'b1;
							cmd.mode_nxt = weas_pkg::MODE_MONITOR;
						end
					end
					default: begin
						if (stat.ok) begin
							cmd.mode_we  = 1'b1;
							cmd.mode_nxt = weas_pkg::MODE_MONITOR;
						end
					end
				endcase
			end
			weas_pkg::OP_CONFIRM: begin
				if (stat.mode != weas_pkg::MODE_ALERT || !label_ok) begin
					cmd.refused = 1'b1;
				end else begin
					cmd.label_we = 1'b1;
					cmd.mode_we  = 1'b1;
					cmd.mode_nxt = weas_pkg::MODE_CONFIRMED;
				end
			end
			weas_pkg::OP_REJECT: begin
				if (stat.mode != weas_pkg::MODE_ALERT) begin
					cmd.refused = 1'b1;
				end else begin
					cmd.label_we  = 1'b1;
					cmd.label_val = weas_pkg::LABEL_FALSE_POS;
					cmd.mode_we   = 1'b1;
					cmd.mode_nxt  = weas_pkg::MODE_REJECTED;
				end
			end
			weas_pkg::OP_UNUSED: begin
				cmd.refused = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= cmd.cand_accum ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (stat.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire
